// File: hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // Field widths fixed by the interface
    localparam int TAG_W   = 8;
    localparam int SIZE_W  = 17;
    localparam int ADDR_W  = 16;
    localparam int ORDER_W = 5;
    localparam int POW_W   = SIZE_W + 1;

    localparam logic [ORDER_W-1:0] TOTAL_ORDER_RST = 5'd10;
    // Rounding stops here even if the size is not reached
    localparam logic [ORDER_W-1:0] REQ_LIMIT       = 5'd17;

    // Register map (index taken from paddr[2])
    localparam logic REG_TOTAL_ORDER = 1'b0;

    typedef struct packed {
        logic [TAG_W-1:0]  request_tag;
        logic [SIZE_W-1:0] request_size;
    } req_t;

    typedef struct packed {
        logic [TAG_W-1:0]  result_tag;
        logic              granted;
        logic [ADDR_W-1:0] start_address;
        logic [SIZE_W-1:0] block_size;
    } rsp_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_LOAD       = 3'd0,
        OP_STEP_REQ   = 3'd1,
        OP_INIT_SCAN  = 3'd2,
        OP_STEP_SCAN  = 3'd3,
        OP_TAKE       = 3'd4,
        OP_SPLIT      = 3'd5,
        OP_EMIT_GRANT = 3'd6,
        OP_EMIT_FAIL  = 3'd7
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        CC_ACCEPT     = 3'd0,
        CC_ROUND_BUSY = 3'd1,
        CC_ABOVE_TOP  = 3'd2,
        CC_SCAN_MORE  = 3'd3,
        CC_MISS       = 3'd4,
        CC_SPLIT_MORE = 3'd5,
        CC_OUT_FREE   = 3'd6
    } cond_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_ROUND = 3'd1;
    localparam step_t STEP_CHECK = 3'd2;
    localparam step_t STEP_SCAN  = 3'd3;
    localparam step_t STEP_TAKE  = 3'd4;
    localparam step_t STEP_SPLIT = 3'd5;
    localparam step_t STEP_GRANT = 3'd6;
    localparam step_t STEP_FAIL  = 3'd7;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;   // next step when the condition holds
        step_t fall;   // next step otherwise
    } ucode_t;

    // Control store
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        case (pc)
            STEP_IDLE:  w = '{OP_LOAD,       CC_ACCEPT,     STEP_ROUND, STEP_IDLE};
            STEP_ROUND: w = '{OP_STEP_REQ,   CC_ROUND_BUSY, STEP_ROUND, STEP_CHECK};
            STEP_CHECK: w = '{OP_INIT_SCAN,  CC_ABOVE_TOP,  STEP_FAIL,  STEP_SCAN};
            STEP_SCAN:  w = '{OP_STEP_SCAN,  CC_SCAN_MORE,  STEP_SCAN,  STEP_TAKE};
            STEP_TAKE:  w = '{OP_TAKE,       CC_MISS,       STEP_FAIL,  STEP_SPLIT};
            STEP_SPLIT: w = '{OP_SPLIT,      CC_SPLIT_MORE, STEP_SPLIT, STEP_GRANT};
            STEP_GRANT: w = '{OP_EMIT_GRANT, CC_OUT_FREE,   STEP_IDLE,  STEP_GRANT};
            STEP_FAIL:  w = '{OP_EMIT_FAIL,  CC_OUT_FREE,   STEP_IDLE,  STEP_FAIL};
            default:    w = '{OP_LOAD,       CC_ACCEPT,     STEP_ROUND, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  s_data  (bba_pkg::req_t: tag, size)
// m_        out  m_valid / m_ready  m_data  (bba_pkg::rsp_t: tag, grant, addr, size)
// apb       in   psel/penable/pwrite, pready tied high; total_order at byte 0
//
// One request at a time, run by an 8-step microprogram: the size is rounded up
// to 2^req (req 0..17), orders from the request order up are scanned for a free
// block, the block is taken and split down to the request order, then emitted.
// A request above the total order fails without a scan. Reset leaves one
// free block of 2^10 units at address 0. A new request is taken while the last
// result waits; the program only stalls on its emit step.

module buddy_block_allocator #(
    parameter int MAX_ORDER = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bba_pkg::req_t        s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output bba_pkg::rsp_t        m_data,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IDX_W = $clog2(MAX_ORDER + 1);
    localparam int OW    = bba_pkg::ORDER_W;

    // Saturate the configured order to the largest supported order
    function automatic logic [OW-1:0] sat_order(input logic [OW-1:0] v);
        return (v > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : v;
    endfunction

    // One whole free block at the saturated order
    function automatic logic [MAX_ORDER:0] one_block(input logic [OW-1:0] ord);
        logic [MAX_ORDER:0] v;
        v = '0;
        v[IDX_W'(sat_order(ord))] = 1'b1;
        return v;
    endfunction

    // Configuration
    logic [OW-1:0] total_order_reg;
    logic [OW-1:0] top;
    logic          cfg_wr;

    // Free lists: at most one block per order
    logic [MAX_ORDER:0]                valid_reg;
    logic [bba_pkg::ADDR_W-1:0]        addr_reg [0:MAX_ORDER];

    // Sequencer and datapath
    bba_pkg::step_t                    pc_reg;
    bba_pkg::step_t                    pc_next;
    bba_pkg::ucode_t                   uw;
    logic                              cond_hit;

    logic [bba_pkg::TAG_W-1:0]         tag_reg;
    logic [bba_pkg::SIZE_W-1:0]        size_reg;
    logic [OW-1:0]                     req_reg;
    logic [bba_pkg::POW_W-1:0]         pow_reg;
    logic [OW-1:0]                     scan_reg;
    logic [bba_pkg::ADDR_W-1:0]        start_reg;

    logic                              m_valid_reg;
    bba_pkg::rsp_t                     m_data_reg;

    logic                              accept;
    logic                              out_free;
    logic                              emit;
    logic                              round_done;
    logic [IDX_W-1:0]                  scan_idx;
    logic                              found;
    logic                              scan_more;
    logic                              split_more;
    logic [OW-1:0]                     split_ord;
    logic [IDX_W-1:0]                  split_idx;
    logic [bba_pkg::ADDR_W-1:0]        buddy_addr;

    assign top      = sat_order(total_order_reg);
    assign cfg_wr   = psel & penable & pwrite & pready
                      & (paddr[2] == bba_pkg::REG_TOTAL_ORDER);

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == bba_pkg::REG_TOTAL_ORDER)
                      ? {{(32-OW){1'b0}}, total_order_reg} : 32'd0;

    assign s_ready  = (pc_reg == bba_pkg::STEP_IDLE);
    assign accept   = s_valid & s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = ~m_valid_reg | m_ready;
    // result register loads on either emit step once it is free
    assign emit     = out_free && ((uw.op == bba_pkg::OP_EMIT_GRANT)
                                   || (uw.op == bba_pkg::OP_EMIT_FAIL));

    // Rounding: stop once 2^req covers the size or the limit is hit
    assign round_done = (req_reg == bba_pkg::REQ_LIMIT) || (pow_reg >= {1'b0, size_reg});

    assign scan_idx   = scan_reg[IDX_W-1:0];
    assign found      = valid_reg[scan_idx];
    assign scan_more  = ~found && (scan_reg < top);
    assign split_more = {1'b0, scan_reg} > ({1'b0, req_reg} + (OW+1)'(1));

    // Upper buddy at the next order down; past bit 15 the offset wraps to 0
    assign split_ord  = scan_reg - OW'(1);
    assign split_idx  = split_ord[IDX_W-1:0];
    assign buddy_addr = start_reg + ((split_ord < OW'(bba_pkg::ADDR_W))
                        ? (bba_pkg::ADDR_W'(1) << split_ord[3:0]) : '0);

    // Microcode fetch and branch
    always_comb begin
        uw = bba_pkg::ucode_rom(pc_reg);
        case (uw.cond)
            bba_pkg::CC_ACCEPT:     cond_hit = accept;
            bba_pkg::CC_ROUND_BUSY: cond_hit = ~round_done;
            bba_pkg::CC_ABOVE_TOP:  cond_hit = (req_reg > top);
            bba_pkg::CC_SCAN_MORE:  cond_hit = scan_more;
            bba_pkg::CC_MISS:       cond_hit = ~found;
            bba_pkg::CC_SPLIT_MORE: cond_hit = split_more;
            bba_pkg::CC_OUT_FREE:   cond_hit = out_free;
            default:                cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? uw.jump : uw.fall;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= bba_pkg::STEP_IDLE;
            m_valid_reg     <= 1'b0;
            total_order_reg <= bba_pkg::TOTAL_ORDER_RST;
            valid_reg       <= one_block(bba_pkg::TOTAL_ORDER_RST);
            for (int i = 0; i <= MAX_ORDER; i++) begin
                addr_reg[i] <= '0;
            end
        end else begin
            pc_reg <= pc_next;

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                // rebuild: one whole free block at address 0
                total_order_reg <= pwdata[OW-1:0];
                valid_reg       <= one_block(pwdata[OW-1:0]);
                for (int i = 0; i <= MAX_ORDER; i++) begin
                    addr_reg[i] <= '0;
                end
            end

            case (uw.op)
                bba_pkg::OP_LOAD: begin
                    if (accept) begin
                        tag_reg  <= s_data.request_tag;
                        size_reg <= (s_data.request_size == '0)
                                    ? bba_pkg::SIZE_W'(1) : s_data.request_size;
                        req_reg  <= '0;
                        pow_reg  <= bba_pkg::POW_W'(1);
                    end
                end
                bba_pkg::OP_STEP_REQ: begin
                    if (!round_done) begin
                        req_reg <= req_reg + OW'(1);
                        pow_reg <= pow_reg << 1;
                    end
                end
                bba_pkg::OP_INIT_SCAN: begin
                    scan_reg <= req_reg;
                end
                bba_pkg::OP_STEP_SCAN: begin
                    if (scan_more) begin
                        scan_reg <= scan_reg + OW'(1);
                    end
                end
                bba_pkg::OP_TAKE: begin
                    if (found) begin
                        start_reg           <= addr_reg[scan_idx];
                        valid_reg[scan_idx] <= 1'b0;
                        addr_reg[scan_idx]  <= '0;
                    end
                end
                bba_pkg::OP_SPLIT: begin
                    if (scan_reg > req_reg) begin
                        scan_reg             <= split_ord;
                        valid_reg[split_idx] <= 1'b1;
                        addr_reg[split_idx]  <= buddy_addr;
                    end
                end
                bba_pkg::OP_EMIT_GRANT: begin
                    if (out_free) begin
                        m_data_reg.result_tag    <= tag_reg;
                        m_data_reg.granted       <= 1'b1;
                        m_data_reg.start_address <= start_reg;
                        m_data_reg.block_size    <= pow_reg[bba_pkg::SIZE_W-1:0];
                    end
                end
                bba_pkg::OP_EMIT_FAIL: begin
                    if (out_free) begin
                        m_data_reg.result_tag    <= tag_reg;
                        m_data_reg.granted       <= 1'b0;
                        m_data_reg.start_address <= '0;
                        m_data_reg.block_size    <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
